// ===== hw/rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_KEY_MODULUS  = 2'd0;
    localparam cfg_index_t REG_KEY_EXPONENT = 2'd1;

    // Exponentiation sequencer
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REDUCE = 4'b0010,
        ST_MUL    = 4'b0100,
        ST_SQR    = 4'b1000
    } mexp_state_t;

    // Modular multiplier sequencer
    typedef enum logic [2:0] {
        MM_IDLE = 3'b001,
        MM_DBL  = 3'b010,
        MM_ADD  = 3'b100
    } mm_state_t;

    // Status returned by the modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// ===== hw/rtl/mexp_mulmod.sv =====
`timescale 1ns / 1ps

// Bit-serial modular multiplier: result = a * b mod n, for a < n.
// Scan b from its top bit; double the remainder each step and add a on a set bit.
// One modular add per cycle through a single shared adder/comparator.
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int W = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] n,
    output logic [W-1:0] result,
    output mm_status_t   status
);

    localparam int CNT_W = $clog2(W);

    mm_state_t          state_reg, state_next;
    logic [W-1:0]       r_reg, r_next;
    logic [W-1:0]       a_reg, a_next;
    logic [W-1:0]       b_reg, b_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic [W-1:0]       addend;
    logic [W:0]         sum;
    logic [W+1:0]       diff;
    logic [W-1:0]       add_mod;
    logic               last;

    // Shared modular adder: operands are below n, so one conditional subtract suffices
    assign addend  = (state_reg == MM_ADD) ? a_reg : r_reg;
    assign sum     = {1'b0, r_reg} + {1'b0, addend};
    assign diff    = {1'b0, sum} - {2'b00, n};
    assign add_mod = diff[W+1] ? sum[W-1:0] : diff[W-1:0];
    assign last    = (cnt_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MM_IDLE:
            begin
                if (go)
                begin
                    a_next     = a;
                    b_next     = b;
                    r_next     = '0;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = MM_DBL;
                end
            end
            MM_DBL:
            begin
                r_next = add_mod;
                if (b_reg[W-1])
                begin
                    state_next = MM_ADD;
                end
                else
                begin
                    b_next   = b_reg << 1;
                    cnt_next = cnt_reg - 1'b1;
                    if (last)
                    begin
                        state_next = MM_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            MM_ADD:
            begin
                r_next   = add_mod;
                b_next   = b_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (last)
                begin
                    state_next = MM_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = MM_DBL;
                end
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
    end

    assign result      = r_reg;
    assign status.busy = (state_reg != MM_IDLE);
    assign status.done = done_reg;

    // The finished remainder is reduced
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < n))
        else $error("mulmod result not below modulus");

    // A finish returns the unit to idle in the same edge
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == MM_IDLE))
        else $error("mulmod done while still running");

    // A go while idle starts a run in the doubling state, without a done
    a_go_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (go && state_reg == MM_IDLE) |=> (state_reg == MM_DBL) && !done_reg)
        else $error("mulmod did not start on go");

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps

// Modular exponentiation core: power_residue = message ^ key_exponent mod key_modulus.
//
// Configuration: write key_modulus (index 0) or key_exponent (index 1) through
// cfg_we / cfg_index / cfg_data while the block is idle; other indexes are dropped.
// Reset loads key_modulus = 2 and key_exponent = 0 and returns the block to idle.
//
// Input: a word is taken on a rising edge with start high and busy low. On a full
// run busy then stays high until the result is out. Output: done pulses for one
// cycle with the result word on power_residue; the receiver cannot stall, so the
// word is lost if not taken in that cycle. power_residue holds until the next result.
//
// Sequence: a zero exponent or a modulus below 2 answers in the cycle after start.
// Otherwise the message is first reduced, then the exponent is scanned from its
// low bit: one modular multiply per set bit, one squaring per bit below the top
// set bit. Every modular multiply runs on one shared bit-serial unit, so an item
// with top exponent bit h needs h + 1 + popcount(e) modular multiplies in all.
// One item is in flight at a time; the multiplier's one-add-per-cycle loop sets
// the rate.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] message,
    output logic                 done,
    output logic [WORD_BITS-1:0] power_residue,
    input  logic                 cfg_we,
    input  cfg_index_t           cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data
);

    localparam int W = WORD_BITS;

    // Key registers
    logic [W-1:0]  key_modulus_reg;
    logic [W-1:0]  key_exponent_reg;

    // Sequencer and working values
    mexp_state_t   state_reg, state_next;
    logic [W-1:0]  exp_reg, exp_next;
    logic [W-1:0]  base_reg, base_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  op_a_reg, op_a_next;
    logic [W-1:0]  op_b_reg, op_b_next;
    logic          mm_go_reg, mm_go_next;
    logic          done_reg, done_next;
    logic [W-1:0]  result_reg, result_next;

    logic [W-1:0]  mm_result;
    mm_status_t    mm_status;

    // Shared modular multiplier; operands and go come from registers
    mexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mm_go_reg),
        .a      (op_a_reg),
        .b      (op_b_reg),
        .n      (key_modulus_reg),
        .result (mm_result),
        .status (mm_status)
    );

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_modulus_reg  <= W'(2);
            key_exponent_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_MODULUS:  key_modulus_reg  <= cfg_data;
                REG_KEY_EXPONENT: key_exponent_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Square-and-multiply sequencer, exponent scanned from bit 0.
    // exp_reg[0] is the bit being worked on; it shifts right after each squaring.
    always_comb
    begin
        state_next  = state_reg;
        exp_next    = exp_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        op_a_next   = op_a_reg;
        op_b_next   = op_b_reg;
        mm_go_next  = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    exp_next = key_exponent_reg;
                    if (key_exponent_reg == '0)
                    begin
                        // Zero exponent: answer 1 whatever the modulus
                        result_next = W'(1);
                        done_next   = 1'b1;
                    end
                    else if (key_modulus_reg < W'(2))
                    begin
                        // Modulus zero or one: nothing survives reduction
                        result_next = '0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        // Reduce the message: 1 * message mod n
                        op_a_next  = W'(1);
                        op_b_next  = message;
                        mm_go_next = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mm_status.done)
                begin
                    base_next  = mm_result;
                    acc_next   = W'(1);
                    mm_go_next = 1'b1;
                    if (exp_reg[0])
                    begin
                        op_a_next  = W'(1);
                        op_b_next  = mm_result;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        op_a_next  = mm_result;
                        op_b_next  = mm_result;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_MUL:
            begin
                if (mm_status.done)
                begin
                    acc_next = mm_result;
                    if (exp_reg[W-1:1] == '0)
                    begin
                        // Top set bit handled: later squarings cannot change acc
                        result_next = mm_result;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        op_a_next  = base_reg;
                        op_b_next  = base_reg;
                        mm_go_next = 1'b1;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_SQR:
            begin
                if (mm_status.done)
                begin
                    base_next  = mm_result;
                    exp_next   = exp_reg >> 1;
                    mm_go_next = 1'b1;
                    if (exp_reg[1])
                    begin
                        op_a_next  = acc_reg;
                        op_b_next  = mm_result;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        // A higher bit is still set, so keep squaring
                        op_a_next  = mm_result;
                        op_b_next  = mm_result;
                        state_next = ST_SQR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mm_go_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mm_go_reg <= mm_go_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        result_reg <= result_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign power_residue = result_reg;

    // A result only leaves once the sequencer is back at idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while sequencer busy");

    // The multiplier never runs or finishes while the sequencer is idle
    a_idle_mm_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!mm_status.busy && !mm_status.done && !mm_go_reg))
        else $error("multiplier active while idle");

    // A zero exponent answers 1 on the next cycle
    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && key_exponent_reg == '0) |=> (done_reg && result_reg == W'(1)))
        else $error("zero exponent did not give 1");

    // A multiplier launch only happens while it is free
    a_go_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        mm_go_reg |-> !mm_status.busy)
        else $error("multiplier launched while busy");

endmodule
